// ----- hw/rtl/low_rank_matrix_reconstruct_core_macros.svh -----
// Assertion macros for the reconstruction core RTL.
// Needs nothing else; included by lrmr_back, the one module that carries assertions.
`ifndef LOW_RANK_MATRIX_RECONSTRUCT_CORE_MACROS_SVH
`define LOW_RANK_MATRIX_RECONSTRUCT_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LRMR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LRMR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lrmr_pkg.sv -----
// Shared types, command codes and default sizes for the reconstruction core.
// No dependencies.
package lrmr_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_RANK = 64;

    localparam int RANK_W = 7;
    localparam logic [RANK_W-1:0] RANK_RESET = 7'd64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SIGMA = 2'd1;
    localparam logic [1:0] CMD_LOAD_RIGHT = 2'd2;
    localparam logic [1:0] CMD_PIXEL      = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         line;
        logic [7:0]         pixel_column;
        logic [5:0]         component;
        logic signed [31:0] value;
    } lrmr_in_t;

    typedef struct packed {
        logic signed [31:0] pixel;
        logic [7:0]         out_row;
        logic [7:0]         out_column;
        logic               clipped;
    } lrmr_out_t;

    // One classified operation as it sits in the queue.
    typedef struct packed {
        logic [1:0]         cmd;
        logic               ok;
        logic [7:0]         line;
        logic [7:0]         col;
        logic [5:0]         comp;
        logic signed [31:0] value;
    } lrmr_op_t;

endpackage

// ----- hw/rtl/lrmr_front.sv -----
// Front end: accepts input transfers and checks each against the store sizes.
// Depends on lrmr_pkg.
module lrmr_front #(
    parameter int MAX_ROWS = lrmr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lrmr_pkg::DEF_MAX_COLS,
    parameter int MAX_RANK = lrmr_pkg::DEF_MAX_RANK
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  lrmr_pkg::lrmr_in_t  s_data,
    output logic                push_valid,
    input  logic                push_ready,
    output lrmr_pkg::lrmr_op_t  push_data
);
    import lrmr_pkg::*;

    logic row_ok;
    logic col_ok;
    logic line_col_ok;
    logic comp_ok;
    logic ok;

    assign row_ok      = 32'(s_data.line) < MAX_ROWS;
    assign line_col_ok = 32'(s_data.line) < MAX_COLS;
    assign col_ok      = 32'(s_data.pixel_column) < MAX_COLS;
    assign comp_ok     = 32'(s_data.component) < MAX_RANK;

    always_comb begin
        case (s_data.command)
            CMD_LOAD_LEFT:  ok = row_ok && comp_ok;
            CMD_LOAD_SIGMA: ok = comp_ok;
            CMD_LOAD_RIGHT: ok = line_col_ok && comp_ok;
            CMD_PIXEL:      ok = row_ok && col_ok;
            default:        ok = 1'b0;
        endcase
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data.cmd   = s_data.command;
        push_data.ok    = ok;
        push_data.line  = s_data.line;
        push_data.col   = s_data.pixel_column;
        push_data.comp  = s_data.component;
        push_data.value = s_data.value;
    end

endmodule

// ----- hw/rtl/lrmr_queue.sv -----
// Short FIFO of classified operations between front end and back end.
// Depends on lrmr_pkg.
module lrmr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  lrmr_pkg::lrmr_op_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lrmr_pkg::lrmr_op_t  pop_data
);
    import lrmr_pkg::*;

    lrmr_op_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/lrmr_back.sv -----
// Back end: factor stores, pipelined multiply-accumulate, saturation and
// the result register. Depends on lrmr_pkg and the core macro header.
`include "low_rank_matrix_reconstruct_core_macros.svh"

module lrmr_back #(
    parameter int MAX_ROWS = lrmr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lrmr_pkg::DEF_MAX_COLS,
    parameter int MAX_RANK = lrmr_pkg::DEF_MAX_RANK
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lrmr_pkg::RANK_W-1:0] rank_used,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  lrmr_pkg::lrmr_op_t          pop_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lrmr_pkg::lrmr_out_t         m_data
);
    import lrmr_pkg::*;

    localparam int RW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW          = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int KW          = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int RNK_W       = $clog2(MAX_RANK + 1);
    localparam int LEFT_DEPTH  = 1 << (RW + KW);
    localparam int RIGHT_DEPTH = 1 << (CW + KW);
    localparam int SIG_DEPTH   = 1 << KW;
    localparam int TERM_W      = 34;
    localparam int ACC_W       = TERM_W + KW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic signed [15:0] left_mem  [LEFT_DEPTH];
    logic signed [15:0] right_mem [RIGHT_DEPTH];
    logic signed [31:0] sig_mem   [SIG_DEPTH];

    logic [1:0]             state_reg, state_next;
    logic [KW-1:0]          k_reg, k_next;
    logic [RNK_W-1:0]       r_reg, r_next;
    lrmr_op_t               op_reg, op_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                   vld1_reg, vld2_reg, vld3_reg;
    logic                   last1_reg, last2_reg, last3_reg;
    logic                   out_valid_reg, out_valid_next;
    lrmr_out_t              out_reg, out_next;

    logic signed [15:0]     left_rd_reg;
    logic signed [15:0]     right_rd_reg;
    logic signed [31:0]     sig_rd_reg;
    logic signed [15:0]     v_d_reg;
    logic signed [47:0]     prod1_reg;
    logic signed [48:0]     prod2_reg;

    logic                   we_left, we_right, we_sig;
    logic                   iss, iss_last;
    logic [KW:0]            k_inc;
    logic [RNK_W-1:0]       r_cap;
    logic signed [32:0]     t_val;
    logic signed [TERM_W-1:0] term;
    logic                   pos_ovf, neg_ovf;
    logic [RW+KW-1:0]       left_waddr, left_raddr;
    logic [CW+KW-1:0]       right_waddr, right_raddr;

    assign r_cap = (32'(rank_used) > MAX_RANK) ? RNK_W'(MAX_RANK) : RNK_W'(rank_used);
    assign k_inc = (KW+1)'(k_reg) + 1'b1;
    assign iss      = state_reg == ST_RUN;
    assign iss_last = iss && (k_inc == (KW+1)'(r_reg));

    assign left_waddr  = {RW'(pop_data.line), KW'(pop_data.comp)};
    assign right_waddr = {CW'(pop_data.line), KW'(pop_data.comp)};
    assign left_raddr  = {RW'(op_reg.line), k_reg};
    assign right_raddr = {CW'(op_reg.col), k_reg};

    // floor(u*s / 2^15), then floor(t*v / 2^15)
    assign t_val = prod1_reg[47:15];
    assign term  = prod2_reg[48:15];

    assign pos_ovf = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:31]);
    assign neg_ovf = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:31]);

    assign pop_ready = state_reg == ST_IDLE;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        r_next         = r_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        we_left        = 1'b0;
        we_right       = 1'b0;
        we_sig         = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (vld3_reg) begin
            acc_next = acc_reg + ACC_W'(term);
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    case (pop_data.cmd)
                        CMD_LOAD_LEFT:  we_left  = pop_data.ok;
                        CMD_LOAD_SIGMA: we_sig   = pop_data.ok;
                        CMD_LOAD_RIGHT: we_right = pop_data.ok;
                        CMD_PIXEL: begin
                            op_next  = pop_data;
                            r_next   = r_cap;
                            k_next   = '0;
                            acc_next = '0;
                            state_next = (pop_data.ok && r_cap != '0) ? ST_RUN : ST_FIN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                k_next = k_reg + 1'b1;
                if (iss_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (vld3_reg && last3_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next     = 1'b1;
                    out_next.out_row    = op_reg.line;
                    out_next.out_column = op_reg.col;
                    out_next.clipped    = pos_ovf || neg_ovf;
                    if (pos_ovf) begin
                        out_next.pixel = 32'sh7FFF_FFFF;
                    end else if (neg_ovf) begin
                        out_next.pixel = 32'sh8000_0000;
                    end else begin
                        out_next.pixel = acc_reg[31:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            r_reg         <= '0;
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
            last1_reg     <= 1'b0;
            last2_reg     <= 1'b0;
            last3_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            r_reg         <= r_next;
            vld1_reg      <= iss;
            vld2_reg      <= vld1_reg;
            vld3_reg      <= vld2_reg;
            last1_reg     <= iss_last;
            last2_reg     <= last1_reg;
            last3_reg     <= last2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: operation, accumulator, result and the multiply pipe.
    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        out_reg   <= out_next;
        v_d_reg   <= right_rd_reg;
        prod1_reg <= left_rd_reg * sig_rd_reg;
        prod2_reg <= t_val * v_d_reg;
    end

    always_ff @(posedge aclk) begin
        if (we_left) begin
            left_mem[left_waddr] <= pop_data.value[15:0];
        end
        left_rd_reg <= left_mem[left_raddr];
    end

    always_ff @(posedge aclk) begin
        if (we_right) begin
            right_mem[right_waddr] <= pop_data.value[15:0];
        end
        right_rd_reg <= right_mem[right_raddr];
    end

    always_ff @(posedge aclk) begin
        if (we_sig) begin
            sig_mem[KW'(pop_data.comp)] <= pop_data.value;
        end
        sig_rd_reg <= sig_mem[k_reg];
    end

    `LRMR_ASSERT_NOW(a_last_in_wait, aclk, aresetn, vld3_reg && last3_reg, state_reg == ST_WAIT, "last product reached the accumulator outside the drain state")
    `LRMR_ASSERT_NOW(a_pipe_empty_fin, aclk, aresetn, state_reg == ST_FIN, !vld1_reg && !vld2_reg && !vld3_reg, "multiply pipe busy while the result is formed")
    `LRMR_ASSERT_NOW(a_one_last, aclk, aresetn, 1'b1, $countones({vld1_reg && last1_reg, vld2_reg && last2_reg, vld3_reg && last3_reg}) <= 1, "more than one pixel in the multiply pipe")
    `LRMR_ASSERT_NEXT(a_run_to_wait, aclk, aresetn, iss_last, state_reg == ST_WAIT && vld1_reg && last1_reg, "last component issue did not start the drain")

endmodule

// ----- hw/rtl/low_rank_matrix_reconstruct_core.sv -----
// Top level of the rank-limited reconstruction core: config register and
// front end, queue and back end. Depends on lrmr_pkg, lrmr_front, lrmr_queue, lrmr_back.
//
// Usage:
//   s_valid/s_ready/s_data carry commands: three load kinds that fill the left
//   factor, singular value and right factor stores, and pixel requests.
//   m_valid/m_ready/m_data return one result per pixel request, in order;
//   loads return nothing. cfg_valid/cfg_ready/cfg_data write rank_used; write
//   it only while the core is idle.
//   Every input transfer lands in a 4-entry queue; the back end takes one
//   operation at a time. A load writes its store as it is taken from the queue. A
//   pixel request with r = min(rank_used, MAX_RANK) components runs one
//   component per cycle through the shared multiply-accumulate: it is taken
//   from the queue, its r components are issued, pass the multiply pipe and
//   are summed, and the sum is saturated into the result register. The back
//   end takes no new operation until then. A zero rank or out-of-range
//   request returns 0 without using the multiply-accumulate.
//   Reset empties the queue and pipeline, drops any pending result and sets
//   rank_used to 64; store contents are left as they are.
//   When the receiver stalls, the result register holds; loads keep retiring
//   until the next pixel needs the register, then the queue fills and
//   s_ready drops.
module low_rank_matrix_reconstruct_core #(
    parameter int MAX_ROWS = lrmr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lrmr_pkg::DEF_MAX_COLS,
    parameter int MAX_RANK = lrmr_pkg::DEF_MAX_RANK
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lrmr_pkg::lrmr_in_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lrmr_pkg::lrmr_out_t         m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [lrmr_pkg::RANK_W-1:0] cfg_data
);
    import lrmr_pkg::*;

    logic [RANK_W-1:0] rank_used_reg, rank_used_next;

    logic     push_valid, push_ready;
    lrmr_op_t push_data;
    logic     pop_valid, pop_ready;
    lrmr_op_t pop_data;

    // Configuration writes are always accepted; cfg_ready is tied high.
    assign cfg_ready      = 1'b1;
    assign rank_used_next = (cfg_valid && cfg_ready) ? cfg_data : rank_used_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_used_reg <= RANK_RESET;
        end else begin
            rank_used_reg <= rank_used_next;
        end
    end

    // Classify each transfer against the store sizes.
    lrmr_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_RANK (MAX_RANK)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple acceptance from execution.
    lrmr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Execute loads and pixel sums; hold the result until transferred.
    lrmr_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_RANK (MAX_RANK)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rank_used (rank_used_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- bench/tb_low_rank_matrix_reconstruct_core.sv -----
// Self-checking testbench for low_rank_matrix_reconstruct_core: drives load and pixel
// transfers, predicts every pixel from its own copy of the factor stores and rank_used.
// Depends on lrmr_pkg and the core RTL only.
module tb_low_rank_matrix_reconstruct_core;
    import lrmr_pkg::*;

    // Cycles to let stray loads retire once the last pixel has come back.
    localparam int SETTLE_CYCLES = 20;
    // Long receiver hold-off, long enough to fill the input queue.
    localparam int HOLD_CYCLES   = 300;
    // Cycles with no transfer on any channel before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;

    localparam longint PIX_MAX = 64'sd2147483647;
    localparam longint PIX_MIN = -64'sd2147483648;

    typedef enum int {RX_STREAM, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    lrmr_in_t            s_data;
    logic                m_valid;
    logic                m_ready;
    lrmr_out_t           m_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [RANK_W-1:0]   cfg_data;

    // Predictor state: its own copy of the three stores and the rank register.
    logic signed [15:0]  left_factor [0:16383];
    logic signed [15:0]  right_factor [0:16383];
    logic signed [31:0]  singular_value [0:63];
    bit [63:0]           left_written [256];
    bit [63:0]           right_written [256];
    bit [63:0]           sigma_written;
    logic [RANK_W-1:0]   rank_setting;

    lrmr_out_t           expected_pixels [$];
    logic [7:0]          line_pool [8];

    int                  mismatch_count;
    int                  pixels_checked;
    int                  clipped_seen;
    int                  loads_done;
    int                  rank_writes;
    int                  items_sent;
    int                  holds_done;
    int                  idle_cycles;
    int                  burst_left;
    bit                  sender_gaps;
    int                  hold_requests;

    low_rank_matrix_reconstruct_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Clamp the programmed rank to the store depth.
    function automatic int eff_rank();
        return (rank_setting > DEF_MAX_RANK) ? DEF_MAX_RANK : int'(rank_setting);
    endfunction

    // Sum the first eff_rank() components of u * sigma * v, floor-shifting each
    // product by 15, then saturate the wide sum to a signed 32-bit Q24.8 value.
    function automatic lrmr_out_t reconstruct_pixel(input logic [7:0] row,
                                                    input logic [7:0] col);
        lrmr_out_t res;
        longint    acc;
        longint    u;
        longint    s;
        longint    v;
        longint    t;
        int        k;
        int        r;
        acc = 0;
        r = eff_rank();
        for (k = 0; k < r; k++) begin
            u = left_factor[{row, 6'(k)}];
            s = singular_value[k];
            v = right_factor[{col, 6'(k)}];
            t = (u * s) >>> 15;
            acc += (t * v) >>> 15;
        end
        res.clipped = 1'b0;
        if (acc > PIX_MAX) begin
            acc = PIX_MAX;
            res.clipped = 1'b1;
        end else if (acc < PIX_MIN) begin
            acc = PIX_MIN;
            res.clipped = 1'b1;
        end
        res.pixel      = acc[31:0];
        res.out_row    = row;
        res.out_column = col;
        return res;
    endfunction

    // Apply one accepted input transfer to the predictor: fill a store or
    // queue the expected pixel.
    task automatic absorb_transfer(input lrmr_in_t it);
        case (it.command)
            CMD_LOAD_LEFT: begin
                left_factor[{it.line, it.component}] = it.value[15:0];
                left_written[it.line][it.component] = 1'b1;
                loads_done++;
            end
            CMD_LOAD_SIGMA: begin
                singular_value[it.component] = it.value;
                sigma_written[it.component] = 1'b1;
                loads_done++;
            end
            CMD_LOAD_RIGHT: begin
                right_factor[{it.line, it.component}] = it.value[15:0];
                right_written[it.line][it.component] = 1'b1;
                loads_done++;
            end
            default: begin
                expected_pixels.push_back(reconstruct_pixel(it.line, it.pixel_column));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one item: when the old burst is used up, open a new one, after a random
    // gap if sender_gaps is set; then hold valid and payload until the transfer happens.
    task automatic send_item(input lrmr_in_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        absorb_transfer(it);
    endtask

    task automatic send_load(input logic [1:0] cmd, input logic [7:0] ln,
                             input logic [5:0] comp, input logic [31:0] val);
        lrmr_in_t it;
        it.command      = cmd;
        it.line         = ln;
        it.pixel_column = 8'($urandom_range(0, 255));
        it.component    = comp;
        it.value        = val;
        send_item(it);
    endtask

    task automatic send_pixel(input logic [7:0] row, input logic [7:0] col);
        lrmr_in_t it;
        it.command      = CMD_PIXEL;
        it.line         = row;
        it.pixel_column = col;
        it.component    = 6'($urandom_range(0, 63));
        it.value        = $urandom();
        send_item(it);
    endtask

    // Drop valid and wait until every pixel is back, then let trailing loads retire.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write rank_used on an idle core.
    task automatic set_rank(input logic [RANK_W-1:0] rank);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= rank;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rank_setting = rank;
        rank_writes++;
    endtask

    // Mostly random words; singular values are often kept small so that
    // sums stay in range, and the extremes come up now and then.
    function automatic logic [31:0] pick_value(input logic [1:0] cmd);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_8000;
                3: return 32'h0000_7FFF;
                4: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (cmd == CMD_LOAD_SIGMA && sel < 5)
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        return $urandom();
    endfunction

    // Pick a row and column whose first eff_rank() components are all written,
    // so that no pixel ever reads an unwritten store entry.
    function automatic bit find_pair(output logic [7:0] row, output logic [7:0] col);
        logic [7:0]  rows [$];
        logic [7:0]  cols [$];
        logic [63:0] mask;
        int          r;
        int          i;
        r = eff_rank();
        mask = (r >= 64) ? '1 : ((64'd1 << r) - 64'd1);
        row = '0;
        col = '0;
        if ((sigma_written & mask) != mask)
            return 1'b0;
        for (i = 0; i < 256; i++) begin
            if ((left_written[i] & mask) == mask)
                rows.push_back(8'(i));
            if ((right_written[i] & mask) == mask)
                cols.push_back(8'(i));
        end
        if (rows.size() == 0 || cols.size() == 0)
            return 1'b0;
        row = rows[$urandom_range(0, rows.size() - 1)];
        col = cols[$urandom_range(0, cols.size() - 1)];
        return 1'b1;
    endfunction

    // Loads mostly hit the pool lines and the active components; the rest
    // scatter over the whole store.
    task automatic send_random_load();
        logic [1:0] cmd;
        logic [7:0] ln;
        logic [5:0] comp;
        int         r;
        cmd = 2'($urandom_range(CMD_LOAD_LEFT, CMD_LOAD_RIGHT));
        ln = ($urandom_range(0, 99) < 85) ? line_pool[$urandom_range(0, 7)]
                                          : 8'($urandom_range(0, 255));
        r = eff_rank();
        comp = (r > 0 && $urandom_range(0, 3) != 0) ? 6'($urandom_range(0, r - 1))
                                                    : 6'($urandom_range(0, 63));
        send_load(cmd, ln, comp, pick_value(cmd));
    endtask

    task automatic send_random_item(input int pixel_pct);
        logic [7:0] row;
        logic [7:0] col;
        if ($urandom_range(0, 99) < pixel_pct && find_pair(row, col))
            send_pixel(row, col);
        else
            send_random_load();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill every singular value, left row 0 and right line 255 at full
    // depth, then request pixels at the reset rank of 64.
    task automatic test_full_rank_fill();
        int k;
        sender_gaps = 1'b1;
        for (k = 0; k < 64; k++) begin
            send_load(CMD_LOAD_SIGMA, 8'($urandom_range(0, 255)), 6'(k),
                      pick_value(CMD_LOAD_SIGMA));
            send_load(CMD_LOAD_LEFT, 8'd0, 6'(k), pick_value(CMD_LOAD_LEFT));
            send_load(CMD_LOAD_RIGHT, 8'd255, 6'(k), pick_value(CMD_LOAD_RIGHT));
        end
        repeat (3) send_pixel(8'd0, 8'd255);
    endtask

    // Saturation both ways, truncation of factor loads to 16 bits, floor
    // rounding of negative products, zero rank and a rank above the depth.
    task automatic test_directed();
        set_rank(7'd2);
        send_load(CMD_LOAD_SIGMA, 8'd0, 6'd0, 32'h8000_0000);
        send_load(CMD_LOAD_SIGMA, 8'd255, 6'd1, 32'h8000_0000);
        send_load(CMD_LOAD_LEFT, 8'd255, 6'd0, 32'hFFFF_8000);
        send_load(CMD_LOAD_LEFT, 8'd255, 6'd1, 32'h0000_8000);
        send_load(CMD_LOAD_RIGHT, 8'd0, 6'd0, 32'h7FFF_7FFF);
        send_load(CMD_LOAD_RIGHT, 8'd0, 6'd1, 32'h0000_7FFF);
        send_pixel(8'd255, 8'd0);       // positive overflow
        send_load(CMD_LOAD_RIGHT, 8'd0, 6'd0, 32'hFFFF_8000);
        send_load(CMD_LOAD_RIGHT, 8'd0, 6'd1, 32'h1234_8000);
        send_pixel(8'd255, 8'd0);       // negative overflow
        send_load(CMD_LOAD_SIGMA, 8'd0, 6'd1, 32'h7FFF_FFFF);
        send_pixel(8'd255, 8'd0);       // terms nearly cancel to -1
        send_pixel(8'd0, 8'd255);
        send_load(CMD_LOAD_LEFT, 8'd85, 6'd0, 32'h0000_0000);
        send_load(CMD_LOAD_LEFT, 8'd85, 6'd1, 32'hFFFF_FFFF);
        send_load(CMD_LOAD_RIGHT, 8'd170, 6'd0, 32'h0000_0001);
        send_load(CMD_LOAD_RIGHT, 8'd170, 6'd1, 32'h0000_FFFF);
        send_pixel(8'd85, 8'd170);
        send_load(CMD_LOAD_LEFT, 8'd0, 6'd63, 32'h7FFF_FFFF);
        set_rank(7'd0);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd1, 8'd200);       // nothing is read at rank 0
        set_rank(7'd127);
        send_pixel(8'd0, 8'd255);
        set_rank(7'd65);
        send_pixel(8'd0, 8'd255);
        set_rank(7'd1);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd255, 8'd255);
    endtask

    // Hold the receiver off for a long stretch while pixels keep coming, so
    // the queue fills and s_ready drops; then drain.
    task automatic test_receiver_hold();
        int i;
        set_rank(7'd4);
        sender_gaps = 1'b1;
        hold_requests++;
        for (i = 0; i < 30; i++)
            send_random_item(75);
        wait_idle();
    endtask

    // One rank setting: below full depth, prime a pool row and column up to
    // the rank, then a random mix of pixels and loads.
    task automatic run_rank_phase(input logic [RANK_W-1:0] rank, input int n_items,
                                  input bit gaps_on);
        logic [7:0] row;
        logic [7:0] col;
        int         start;
        int         r;
        int         k;
        set_rank(rank);
        sender_gaps = gaps_on;
        start = items_sent;
        r = eff_rank();
        if (r > 0 && r < 64) begin
            row = line_pool[$urandom_range(0, 7)];
            col = line_pool[$urandom_range(0, 7)];
            for (k = 0; k < r; k++) begin
                send_load(CMD_LOAD_LEFT, row, 6'(k), pick_value(CMD_LOAD_LEFT));
                send_load(CMD_LOAD_RIGHT, col, 6'(k), pick_value(CMD_LOAD_RIGHT));
            end
        end
        while (items_sent - start < n_items)
            send_random_item(45);
    endtask

    task automatic test_random_ranks();
        logic [RANK_W-1:0] ranks [8];
        int                i;
        ranks = '{7'd3, 7'd127, 7'd1, 7'($urandom_range(2, 12)), 7'd0, 7'd65,
                  7'($urandom_range(4, 20)), 7'd64};
        for (i = 0; i < 8; i++)
            run_rank_phase(ranks[i], 38, (i % 3) != 2);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // Compare every result transfer against the oldest expected pixel.
    always @(posedge aclk) begin : result_check
        lrmr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending (row %0d col %0d)",
                                          m_data.out_row, m_data.out_column));
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.pixel !== want.pixel)
                    report_mismatch($sformatf("pixel (%0d,%0d): got %0d want %0d",
                                              want.out_row, want.out_column,
                                              m_data.pixel, want.pixel));
                if (m_data.out_row !== want.out_row)
                    report_mismatch($sformatf("out_row: got %0d want %0d",
                                              m_data.out_row, want.out_row));
                if (m_data.out_column !== want.out_column)
                    report_mismatch($sformatf("out_column: got %0d want %0d",
                                              m_data.out_column, want.out_column));
                if (m_data.clipped !== want.clipped)
                    report_mismatch($sformatf("clipped (%0d,%0d): got %b want %b",
                                              want.out_row, want.out_column,
                                              m_data.clipped, want.clipped));
                pixels_checked++;
                if (want.clipped)
                    clipped_seen++;
            end
        end
    end

    // Receiver: take a long hold-off when asked, otherwise cycle through
    // stall patterns of its own, including stretches that never stall.
    initial begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       stall_left;
        int       beat;
        m_ready <= 1'b0;
        mode = RX_STREAM;
        mode_left = 0;
        stall_left = 0;
        beat = 0;
        forever begin
            @(posedge aclk);
            if (holds_done < hold_requests) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(RX_STREAM, RX_BURSTY));
                    mode_left = $urandom_range(40, 160);
                end
                mode_left--;
                beat++;
                case (mode)
                    RX_STREAM: begin
                        m_ready <= 1'b1;
                    end
                    RX_COIN: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    RX_PERIODIC: begin
                        m_ready <= (beat % 5) != 0;
                    end
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            m_ready <= 1'b0;
                        end else begin
                            m_ready <= 1'b1;
                            if ($urandom_range(0, 7) == 0)
                                stall_left = $urandom_range(1, 20);
                        end
                    end
                endcase
            end
        end
    end

    // Watchdog: end the run when no channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d pixels pending",
                     idle_cycles, expected_pixels.size());
            $display("low_rank_matrix_reconstruct_core: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        rank_setting = RANK_RESET;
        burst_left = 0;
        sender_gaps = 1'b1;
        line_pool = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd85, 8'd170,
                      8'($urandom_range(2, 127)), 8'($urandom_range(129, 254))};

        // Hold reset once at the start, then release it.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_full_rank_fill();
        test_directed();
        test_receiver_hold();
        test_random_ranks();
        wait_idle();

        $display("covered %0d loads and %0d pixel results (%0d saturated) over %0d rank writes,",
                 loads_done, pixels_checked, clipped_seen, rank_writes);
        $display("with %0d long receiver hold-off(s) and random gaps on both channels",
                 holds_done);
        if (mismatch_count == 0) begin
            $display("low_rank_matrix_reconstruct_core: match");
        end else begin
            $display("low_rank_matrix_reconstruct_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lrmr_pkg.sv
hw/rtl/lrmr_front.sv
hw/rtl/lrmr_queue.sv
hw/rtl/lrmr_back.sv
hw/rtl/low_rank_matrix_reconstruct_core.sv
bench/tb_low_rank_matrix_reconstruct_core.sv
